FILE: design/rpb_pkg.sv
// Shared types and constants for the RGB pixel blend unit.
// No dependencies; compile first.
`default_nettype none

package rpb_pkg;

  typedef logic [7:0] pix_t;

  typedef enum logic [2:0] {
    MODE_MULTIPLY = 3'd0,
    MODE_SUBTRACT = 3'd1,
    MODE_REV_SUB  = 3'd2,
    MODE_SCREEN   = 3'd3,
    MODE_OVERLAY  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_PROD = 2'd0,
    KIND_DIFF = 2'd1,
    KIND_ZERO = 2'd2
  } kind_t;

  localparam int NUM_STAGES = 4;

  localparam int PROD_W  = 16;
  localparam int SUM_W   = 18;
  localparam int RECIP_W = 19;
  localparam int SCALE_W = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 26;

  // ceil(2^26 / 255); exact floor(t / 255) for every t below 2^18
  localparam logic [RECIP_W-1:0] RECIP_255  = 19'd263173;
  localparam logic [SUM_W-1:0]   ROUND_BIAS = 18'd127;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: design/rpb_in_if.sv
// Input channel interface: one top/other RGB pixel pair per transaction.
// Depends on rpb_pkg.
`default_nettype none

interface rpb_in_if;
  import rpb_pkg::*;

  logic valid;
  logic ready;
  pix_t top_red;
  pix_t top_green;
  pix_t top_blue;
  pix_t other_red;
  pix_t other_green;
  pix_t other_blue;

  modport source (
    output valid, top_red, top_green, top_blue, other_red, other_green, other_blue,
    input  ready
  );
  modport sink (
    input  valid, top_red, top_green, top_blue, other_red, other_green, other_blue,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/rpb_out_if.sv
// Result channel interface: one blended RGB pixel per transaction.
// Depends on rpb_pkg.
`default_nettype none

interface rpb_out_if;
  import rpb_pkg::*;

  logic valid;
  logic ready;
  pix_t out_red;
  pix_t out_green;
  pix_t out_blue;

  modport source (
    output valid, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/rpb_pipe.sv
// Pipeline control: per-stage valid bits and load enables with bubble collapse.
// Depends on rpb_pkg.
`default_nettype none

module rpb_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rpb_pkg::pipe_ctl_t     ctl
);
  import rpb_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.load  = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  logic in_acc;
  logic out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> vld_r[0])
    else $error("accepted transaction did not enter first stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input stalled with an empty stage");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(vld_r) ==
      $past($countones(vld_r)) + $past(in_acc) - $past(out_acc)))
    else $error("transaction count not conserved");

endmodule

`default_nettype wire

FILE: design/rpb_chan.sv
// One color channel datapath: operand select, multiply, reciprocal scale, finish.
// Depends on rpb_pkg; load enables come from rpb_pipe.
`default_nettype none

module rpb_chan (
  input  wire logic               clk,
  input  wire rpb_pkg::mode_t     mode,
  input  wire rpb_pkg::pix_t      a,
  input  wire rpb_pkg::pix_t      b,
  input  wire rpb_pkg::pipe_ctl_t ctl,
  output rpb_pkg::pix_t           res
);
  import rpb_pkg::*;

  // stage 1: operands
  pix_t  x_nxt, y_nxt;
  kind_t kind_nxt;
  logic  inv_nxt, dbl_nxt;
  pix_t  s1_x_r, s1_y_r;
  kind_t s1_kind_r;
  logic  s1_inv_r, s1_dbl_r;

  always_comb begin
    x_nxt    = a;
    y_nxt    = b;
    kind_nxt = KIND_PROD;
    inv_nxt  = 1'b0;
    dbl_nxt  = 1'b0;
    unique case (mode)
      MODE_MULTIPLY: begin
      end
      MODE_SUBTRACT: begin
        kind_nxt = KIND_DIFF;
        x_nxt    = (a > b) ? (a - b) : 8'd0;
      end
      MODE_REV_SUB: begin
        kind_nxt = KIND_DIFF;
        x_nxt    = (b > a) ? (b - a) : 8'd0;
      end
      MODE_SCREEN: begin
        x_nxt   = ~a;
        y_nxt   = ~b;
        inv_nxt = 1'b1;
      end
      MODE_OVERLAY: begin
        dbl_nxt = 1'b1;
        if (a[7]) begin
          x_nxt   = ~a;
          y_nxt   = ~b;
          inv_nxt = 1'b1;
        end
      end
      default: begin
        kind_nxt = KIND_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_x_r    <= x_nxt;
      s1_y_r    <= y_nxt;
      s1_kind_r <= kind_nxt;
      s1_inv_r  <= inv_nxt;
      s1_dbl_r  <= dbl_nxt;
    end
  end

  // stage 2: product
  logic [PROD_W-1:0] s2_prod_r;
  pix_t  s2_x_r;
  kind_t s2_kind_r;
  logic  s2_inv_r, s2_dbl_r;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_prod_r <= s1_x_r * s1_y_r;
      s2_x_r    <= s1_x_r;
      s2_kind_r <= s1_kind_r;
      s2_inv_r  <= s1_inv_r;
      s2_dbl_r  <= s1_dbl_r;
    end
  end

  // stage 3: (p + 127) / 255, or (2p + 127) / 255 for overlay, by reciprocal multiply
  logic [SUM_W-1:0]   sum;
  logic [SCALE_W-1:0] s3_scaled_r;
  pix_t  s3_x_r;
  kind_t s3_kind_r;
  logic  s3_inv_r;

  assign sum = (s2_dbl_r ? {1'b0, s2_prod_r, 1'b0} : {2'b00, s2_prod_r}) + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_scaled_r <= SCALE_W'(sum) * SCALE_W'(RECIP_255);
      s3_x_r      <= s2_x_r;
      s3_kind_r   <= s2_kind_r;
      s3_inv_r    <= s2_inv_r;
    end
  end

  // stage 4: finish into output register
  pix_t quot;
  pix_t res_nxt;
  pix_t res_r;

  assign quot = s3_scaled_r[RECIP_SHIFT +: 8];

  always_comb begin
    unique case (s3_kind_r)
      KIND_PROD: res_nxt = s3_inv_r ? ~quot : quot;
      KIND_DIFF: res_nxt = s3_x_r;
      default:   res_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

FILE: design/rgb_pixel_blend_unit.sv
// Top level of the RGB pixel blend unit: mode register, pipeline control, three channels.
// Depends on rpb_pkg, rpb_in_if, rpb_out_if, rpb_pipe and rpb_chan.
//
// Blends a top pixel with an other-layer pixel per channel in the mode held by the
// blend_mode register (multiply, subtract, reverse subtract, screen, overlay; codes
// 5 to 7 give black). One pixel pair is taken every cycle unless the pipeline is full and
// the output stalls; each passes the operand, multiply, divide-by-255 reciprocal and output register stages.
// Empty stages fill while the output stalls, so input keeps flowing until all four
// stages hold a pixel. Write blend_mode only while the pipeline is empty.
`default_nettype none

module rgb_pixel_blend_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  rpb_in_if.sink    in_pix,
  rpb_out_if.source out_pix,
  input  wire logic cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data
);
  import rpb_pkg::*;

  mode_t     mode_r;
  pipe_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MULTIPLY;
    end else if (cfg_wr_en) begin
      mode_r <= mode_t'(cfg_wr_data);
    end
  end

  rpb_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .ctl       (ctl)
  );

  rpb_chan u_red (
    .clk  (clk),
    .mode (mode_r),
    .a    (in_pix.top_red),
    .b    (in_pix.other_red),
    .ctl  (ctl),
    .res  (out_pix.out_red)
  );

  rpb_chan u_green (
    .clk  (clk),
    .mode (mode_r),
    .a    (in_pix.top_green),
    .b    (in_pix.other_green),
    .ctl  (ctl),
    .res  (out_pix.out_green)
  );

  rpb_chan u_blue (
    .clk  (clk),
    .mode (mode_r),
    .a    (in_pix.top_blue),
    .b    (in_pix.other_blue),
    .ctl  (ctl),
    .res  (out_pix.out_blue)
  );

endmodule

`default_nettype wire
